@@ hdl/variance_hysteresis_mode_select_top_macros.svh @@
// Assertion macros shared by the variance mode selector RTL.
`ifndef VARIANCE_HYSTERESIS_MODE_SELECT_TOP_MACROS_SVH
`define VARIANCE_HYSTERESIS_MODE_SELECT_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VHMS_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VHMS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/vhms_pkg.sv @@
// Shared types, codes and width helpers for the variance mode selector.
package vhms_pkg;

    localparam int READ_W = 13;
    localparam int VAR_W  = 32;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_STRAIGHT = 3'd0,
        MODE_APPROACH = 3'd1,
        MODE_CURVE    = 3'd2,
        MODE_OUT      = 3'd3,
        MODE_STUCK    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        REG_STRAIGHT_ENTER = 2'd0,
        REG_STRAIGHT_HOLD  = 2'd1,
        REG_APPROACH_ENTER = 2'd2,
        REG_APPROACH_HOLD  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [VAR_W-1:0] straight_enter;
        logic [VAR_W-1:0] straight_hold;
        logic [VAR_W-1:0] approach_enter;
        logic [VAR_W-1:0] approach_hold;
    } t_thresh;

    // Reading count per frame, up to the sensor count itself
    function automatic int cnt_w(input int sensors);
        return $clog2(sensors + 1);
    endfunction

    // Signed running sum of readings
    function automatic int sum_w(input int sensors);
        return READ_W + $clog2(sensors);
    endfunction

    // Running sum of squares; one square needs 2*READ_W-1 bits
    function automatic int sq_w(input int sensors);
        return 2 * READ_W - 1 + $clog2(sensors);
    endfunction

endpackage

@@ hdl/vhms_front.sv @@
// Front end: accepts readings, squares and accumulates them per frame.
module vhms_front #(
    parameter int SENSORS = 19
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_ready,
    input  logic signed [vhms_pkg::READ_W-1:0]              i_reading,
    input  logic                                            i_stuck_flag,
    input  logic                                            i_frame_end,
    input  logic                                            i_q_ready,
    output logic                                            o_push,
    output logic        [vhms_pkg::cnt_w(SENSORS)-1:0]      o_count,
    output logic signed [vhms_pkg::sum_w(SENSORS)-1:0]      o_sum,
    output logic        [vhms_pkg::sq_w(SENSORS)-1:0]       o_sq,
    output logic                                            o_stuck
);
    import vhms_pkg::*;

    localparam int CNT_W = cnt_w(SENSORS);
    localparam int SUM_W = sum_w(SENSORS);
    localparam int SQ_W  = sq_w(SENSORS);

    logic                      accept;
    logic                      add_en;
    logic signed [2*READ_W-1:0] square;
    logic        [CNT_W-1:0]   r_count, n_count;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic        [SQ_W-1:0]    r_sq, n_sq;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    // Square the reading; extra readings past the sensor count are dropped
    assign square = i_reading * i_reading;
    assign add_en = r_count < CNT_W'(SENSORS);

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sq    = r_sq;
        if (add_en) begin
            n_count = r_count + CNT_W'(1);
            n_sum   = r_sum + SUM_W'(i_reading);
            n_sq    = r_sq + SQ_W'(unsigned'(square));
        end
    end

    // Hand the finished frame totals to the queue
    assign o_push  = accept && i_frame_end;
    assign o_count = n_count;
    assign o_sum   = n_sum;
    assign o_sq    = n_sq;
    assign o_stuck = i_stuck_flag;

    // Advance the accumulators; clear them when the frame ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
        end else if (accept) begin
            if (i_frame_end) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sq    <= '0;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_sq    <= n_sq;
            end
        end
    end

endmodule

@@ hdl/vhms_queue.sv @@
// Two-entry queue of frame totals between the front and back ends.
module vhms_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import vhms_pkg::*;

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_fill;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_fill != 2'd2;
    assign o_valid = r_fill != 2'd0;
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hdl/vhms_back.sv @@
// Back end: scaled variance pipeline, hysteresis mode choice, output register.
module vhms_back #(
    parameter int SENSORS = 19
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_pop,
    input  logic        [vhms_pkg::cnt_w(SENSORS)-1:0]      i_count,
    input  logic signed [vhms_pkg::sum_w(SENSORS)-1:0]      i_sum,
    input  logic        [vhms_pkg::sq_w(SENSORS)-1:0]       i_sq,
    input  logic                                            i_stuck,
    input  vhms_pkg::t_thresh                               i_thresh,
    output logic                                            o_valid,
    input  logic                                            i_ready,
    output vhms_pkg::t_mode                                 o_mode,
    output logic                                            o_mode_changed,
    output logic        [vhms_pkg::VAR_W-1:0]               o_scaled_variance
);
    import vhms_pkg::*;

    localparam int CNT_W = cnt_w(SENSORS);
    localparam int SUM_W = sum_w(SENSORS);
    localparam int SQ_W  = sq_w(SENSORS);
    localparam int PA_W  = CNT_W + SQ_W;
    localparam int PB_W  = 2 * SUM_W;
    localparam int P_W   = (PA_W > PB_W) ? PA_W : PB_W;
    localparam int EXT_W = (P_W > VAR_W) ? P_W : VAR_W + 1;

    logic                 advance;
    logic [SUM_W-1:0]     mag;
    logic [PA_W-1:0]      prod_a;
    logic [PB_W-1:0]      prod_b;
    logic [EXT_W-1:0]     diff;
    logic [VAR_W-1:0]     var_sat;
    t_mode                next_mode;

    logic                 r_v1, r_v2, r_out_valid;
    logic [EXT_W-1:0]     r_a, r_b;
    logic                 r_stuck1, r_stuck2;
    logic [VAR_W-1:0]     r_var;
    t_mode                r_mode;
    t_mode                r_out_mode;
    logic                 r_out_changed;
    logic [VAR_W-1:0]     r_out_var;

    // The whole pipeline moves unless a result waits at the output
    assign advance = !r_out_valid || i_ready;
    assign o_pop   = advance;

    // Stage 1: the two products
    assign mag    = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign prod_a = i_count * i_sq;
    assign prod_b = mag * mag;

    // Stage 2: difference, clamped at zero and saturated to the output range
    assign diff    = (r_a > r_b) ? r_a - r_b : '0;
    assign var_sat = (|diff[EXT_W-1:VAR_W]) ? '1 : diff[VAR_W-1:0];

    // Stage 3: mode choice with hysteresis against the current mode
    always_comb begin
        if (r_stuck2) begin
            next_mode = MODE_STUCK;
        end else if (r_var > i_thresh.straight_enter ||
                     (r_var > i_thresh.straight_hold && r_mode == MODE_STRAIGHT)) begin
            next_mode = MODE_STRAIGHT;
        end else if ((r_var > i_thresh.approach_enter && r_mode != MODE_CURVE) ||
                     (r_var > i_thresh.approach_hold && r_mode == MODE_APPROACH)) begin
            next_mode = MODE_APPROACH;
        end else if (r_var != '0) begin
            next_mode = MODE_CURVE;
        end else begin
            next_mode = MODE_OUT;
        end
    end

    // Advance valid bits and the current mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_STRAIGHT;
        end else if (advance) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
            if (r_v2) begin
                r_mode <= next_mode;
            end
        end
    end

    // Advance the payload through the stages; hold while stalled
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a           <= EXT_W'(prod_a);
            r_b           <= EXT_W'(prod_b);
            r_stuck1      <= i_stuck;
            r_var         <= var_sat;
            r_stuck2      <= r_stuck1;
            r_out_mode    <= next_mode;
            r_out_changed <= next_mode != r_mode;
            r_out_var     <= r_var;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_mode            = r_out_mode;
    assign o_mode_changed    = r_out_changed;
    assign o_scaled_variance = r_out_var;

endmodule

@@ hdl/variance_hysteresis_mode_select_top.sv @@
// Top level of the variance-driven driving mode selector.
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+--------------------------------------
//  input    | i_in_valid / o_in_ready        | i_reading, i_stuck_flag, i_frame_end
//  result   | o_out_valid / i_out_ready      | o_mode, o_mode_changed, o_scaled_variance
//  config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One reading is accepted per cycle unless stalled; the accumulator updates as it is taken.
// A frame's totals pass the queue, then the product, variance and output registers.
// Results flow one per cycle unless stalled: two-entry queue, then a three-stage back end.
// Synchronous active-low reset clears accumulators, queue, thresholds and sets mode straight.
// A stalled result freezes the back end; the front stalls only once the queue is full.
`include "variance_hysteresis_mode_select_top_macros.svh"

module variance_hysteresis_mode_select_top #(
    parameter int SENSORS = 19
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vhms_pkg::ADDR_W-1:0]         paddr,
    input  logic [vhms_pkg::DATA_W-1:0]         pwdata,
    output logic [vhms_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [vhms_pkg::READ_W-1:0]  i_reading,
    input  logic                                i_stuck_flag,
    input  logic                                i_frame_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_mode,
    output logic                                o_mode_changed,
    output logic [vhms_pkg::VAR_W-1:0]          o_scaled_variance
);
    import vhms_pkg::*;

    localparam int CNT_W = cnt_w(SENSORS);
    localparam int SUM_W = sum_w(SENSORS);
    localparam int SQ_W  = sq_w(SENSORS);
    localparam int Q_W   = CNT_W + SUM_W + SQ_W + 1;

    t_thresh                  r_thresh;
    t_reg_idx                 reg_idx;
    logic                     cfg_write;

    logic                     q_push, q_ready, q_valid, q_pop;
    logic [CNT_W-1:0]         f_count;
    logic signed [SUM_W-1:0]  f_sum;
    logic [SQ_W-1:0]          f_sq;
    logic                     f_stuck;
    logic [Q_W-1:0]           q_wdata, q_rdata;
    t_mode                    b_mode;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_STRAIGHT_ENTER: r_thresh.straight_enter <= pwdata;
                REG_STRAIGHT_HOLD:  r_thresh.straight_hold  <= pwdata;
                REG_APPROACH_ENTER: r_thresh.approach_enter <= pwdata;
                REG_APPROACH_HOLD:  r_thresh.approach_hold  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STRAIGHT_ENTER: prdata = r_thresh.straight_enter;
            REG_STRAIGHT_HOLD:  prdata = r_thresh.straight_hold;
            REG_APPROACH_ENTER: prdata = r_thresh.approach_enter;
            REG_APPROACH_HOLD:  prdata = r_thresh.approach_hold;
            default:            prdata = '0;
        endcase
    end

    // Front end: accumulate the frame
    vhms_front #(
        .SENSORS (SENSORS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_reading    (i_reading),
        .i_stuck_flag (i_stuck_flag),
        .i_frame_end  (i_frame_end),
        .i_q_ready    (q_ready),
        .o_push       (q_push),
        .o_count      (f_count),
        .o_sum        (f_sum),
        .o_sq         (f_sq),
        .o_stuck      (f_stuck)
    );

    // Queue of finished frame totals
    assign q_wdata = {f_count, f_sum, f_sq, f_stuck};

    vhms_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_ready (q_ready),
        .i_data  (q_wdata),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    // Back end: variance and mode choice
    vhms_back #(
        .SENSORS (SENSORS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .o_pop             (q_pop),
        .i_count           (q_rdata[Q_W-1 -: CNT_W]),
        .i_sum             (signed'(q_rdata[SQ_W+1 +: SUM_W])),
        .i_sq              (q_rdata[1 +: SQ_W]),
        .i_stuck           (q_rdata[0]),
        .i_thresh          (r_thresh),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_mode            (b_mode),
        .o_mode_changed    (o_mode_changed),
        .o_scaled_variance (o_scaled_variance)
    );

    assign o_mode = b_mode;

    // Out of track means a flat frame, curve means some spread
    `VHMS_CHECK_NOW(a_out_zero_var, o_out_valid && b_mode == MODE_OUT, o_scaled_variance == '0, "out of track result with nonzero variance")
    `VHMS_CHECK_NOW(a_curve_nonzero_var, o_out_valid && b_mode == MODE_CURVE, o_scaled_variance != '0, "curve result with zero variance")
    // A frame total is never pushed into a full queue
    `VHMS_CHECK_NOW(a_push_has_room, q_push, q_ready, "frame pushed into full queue")
    // A stalled result holds steady until it is taken
    `VHMS_CHECK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(b_mode) && $stable(o_scaled_variance), "stalled result changed")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the variance driven mode selector.
module tb;
    import vhms_pkg::*;

    localparam int SENSORS     = 19;
    localparam int LIMIT_CYCLE = 400000;
    localparam int REPORT_CAP  = 10;
    localparam int PHASE_ITEMS = 120;
    localparam int RAND_PHASES = 6;

    typedef struct {
        t_mode            mode;
        logic             changed;
        logic [VAR_W-1:0] variance;
    } t_frame_verdict;

    typedef struct {
        logic signed [READ_W-1:0] reading;
        logic                     stuck;
        logic                     frame_end;
        logic                     pinned;
        t_frame_verdict           verdict;
    } t_scripted_item;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [READ_W-1:0] i_reading = '0;
    logic                     i_stuck_flag = 1'b0;
    logic                     i_frame_end = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [2:0]               o_mode;
    logic                     o_mode_changed;
    logic [VAR_W-1:0]         o_scaled_variance;

    // Predictor state: thresholds, frame accumulators and the mode in force
    logic [VAR_W-1:0] thresholds [4];
    longint           acc_sum;
    longint           acc_sq;
    int               acc_cnt;
    t_mode            mode_now;

    t_frame_verdict   pending_verdicts [$];
    t_scripted_item   script [$];
    t_frame_verdict   no_pin;
    int               mismatches = 0;
    bit               feed_calm = 0;
    bit               drain_calm = 0;
    int               items_fed = 0;
    int               ready_left = 0;

    variance_hysteresis_mode_select_top #(
        .SENSORS(SENSORS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_reading(i_reading),
        .i_stuck_flag(i_stuck_flag),
        .i_frame_end(i_frame_end),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_mode(o_mode),
        .o_mode_changed(o_mode_changed),
        .o_scaled_variance(o_scaled_variance)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input logic [VAR_W-1:0] want,
                                 input logic [VAR_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_CAP) begin
            $display("mismatch: %s expected %0d got %0d", what, want, got);
        end
    endtask

    // Mode choice with hysteresis, first match wins
    function automatic t_mode pick_mode(input logic [VAR_W-1:0] v);
        if (v > thresholds[REG_STRAIGHT_ENTER] ||
            (v > thresholds[REG_STRAIGHT_HOLD] && mode_now == MODE_STRAIGHT)) begin
            return MODE_STRAIGHT;
        end
        if ((v > thresholds[REG_APPROACH_ENTER] && mode_now != MODE_CURVE) ||
            (v > thresholds[REG_APPROACH_HOLD] && mode_now == MODE_APPROACH)) begin
            return MODE_APPROACH;
        end
        if (v > 0) begin
            return MODE_CURVE;
        end
        return MODE_OUT;
    endfunction

    // Accumulate one reading; on frame end form the verdict and clear the sums
    task automatic track_reading(input logic signed [READ_W-1:0] r, input logic stk,
                                 input logic fe, output bit done,
                                 output t_frame_verdict vd);
        longint rv;
        longint scaled;
        rv = longint'(r);
        done = 0;
        vd.mode = MODE_STRAIGHT;
        vd.changed = 1'b0;
        vd.variance = 32'd0;
        if (acc_cnt < SENSORS) begin
            acc_sum += rv;
            acc_sq += rv * rv;
            acc_cnt++;
        end
        if (fe) begin
            scaled = acc_cnt * acc_sq - acc_sum * acc_sum;
            if (scaled < 0) begin
                scaled = 0;
            end
            if (scaled > 64'h0000_0000_FFFF_FFFF) begin
                scaled = 64'h0000_0000_FFFF_FFFF;
            end
            vd.variance = scaled[VAR_W-1:0];
            vd.mode = stk ? MODE_STUCK : pick_mode(vd.variance);
            vd.changed = (vd.mode != mode_now);
            mode_now = vd.mode;
            acc_sum = 0;
            acc_sq = 0;
            acc_cnt = 0;
            done = 1;
        end
    endtask

    function automatic int feed_gap();
        if (feed_calm || $urandom_range(0, 9) < 6) begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offer one item, hold it until taken, then predict and idle a while
    task automatic feed_reading(input logic signed [READ_W-1:0] r, input logic stk,
                                input logic fe, input logic pinned,
                                input t_frame_verdict pin);
        bit done;
        t_frame_verdict vd;
        int gap;
        i_in_valid <= 1'b1;
        i_reading <= r;
        i_stuck_flag <= stk;
        i_frame_end <= fe;
        do @(posedge i_clk); while (!o_in_ready);
        items_fed++;
        track_reading(r, stk, fe, done, vd);
        if (done) begin
            pending_verdicts.push_back(pinned ? pin : vd);
        end
        gap = feed_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_step(input logic signed [READ_W-1:0] r, input logic stk,
                            input logic fe, input logic pinned, input t_mode m,
                            input logic chg, input logic [VAR_W-1:0] v);
        t_scripted_item s;
        s.reading = r;
        s.stuck = stk;
        s.frame_end = fe;
        s.pinned = pinned;
        s.verdict.mode = m;
        s.verdict.changed = chg;
        s.verdict.variance = v;
        script.push_back(s);
    endtask

    // Random frame: clustered, constant, in-range or raw readings
    task automatic feed_random_frame();
        int len;
        int kind;
        int center;
        int spread;
        logic stk;
        logic signed [READ_W-1:0] r;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(SENSORS + 1, SENSORS + 5)
                                          : $urandom_range(1, SENSORS);
        kind = $urandom_range(0, 5);
        center = $urandom_range(0, 3200);
        spread = 1 << $urandom_range(0, 9);
        stk = ($urandom_range(0, 6) == 0);
        for (int k = 0; k < len; k++) begin
            case (kind)
                0: r = READ_W'($urandom);
                4: r = READ_W'(center);
                5: r = READ_W'($urandom_range(0, 3216) - 16);
                default: r = READ_W'(center - spread / 2 + $urandom_range(0, spread));
            endcase
            feed_reading(r, (k == len - 1) ? stk : 1'($urandom_range(0, 1)),
                         k == len - 1, 1'b0, no_pin);
        end
    endtask

    task automatic write_threshold(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        thresholds[idx] = value;
        @(posedge i_clk);
    endtask

    task automatic check_threshold(input t_reg_idx idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== thresholds[idx]) begin
            flag_mismatch("threshold readback", thresholds[idx], prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for the last frame result, let the back end settle, then reprogram
    task automatic set_thresholds(input logic [DATA_W-1:0] se, input logic [DATA_W-1:0] sh,
                                  input logic [DATA_W-1:0] ae, input logic [DATA_W-1:0] ah);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        write_threshold(REG_STRAIGHT_ENTER, se);
        write_threshold(REG_STRAIGHT_HOLD, sh);
        write_threshold(REG_APPROACH_ENTER, ae);
        write_threshold(REG_APPROACH_HOLD, ah);
        check_threshold(REG_STRAIGHT_ENTER);
        check_threshold(REG_STRAIGHT_HOLD);
        check_threshold(REG_APPROACH_ENTER);
        check_threshold(REG_APPROACH_HOLD);
    endtask

    function automatic logic [VAR_W-1:0] scaled_random();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // Result side: check each taken item, then pick the next ready stretch
    always @(posedge i_clk) begin : result_check
        t_frame_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch("result with no frame pending", 0, o_scaled_variance);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_mode !== want.mode) begin
                    flag_mismatch("mode", VAR_W'(want.mode), VAR_W'(o_mode));
                end
                if (o_mode_changed !== want.changed) begin
                    flag_mismatch("mode_changed", VAR_W'(want.changed),
                                  VAR_W'(o_mode_changed));
                end
                if (o_scaled_variance !== want.variance) begin
                    flag_mismatch("scaled_variance", want.variance, o_scaled_variance);
                end
            end
        end
        if (ready_left > 0) begin
            ready_left--;
        end else if (drain_calm || $urandom_range(0, 9) < 7) begin
            i_out_ready <= 1'b1;
            ready_left = $urandom_range(0, 7);
        end else begin
            i_out_ready <= 1'b0;
            ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end
    end

    initial begin
        #(LIMIT_CYCLE * 10);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [VAR_W-1:0] se;
        for (int k = 0; k < 4; k++) begin
            thresholds[k] = '0;
        end
        acc_sum = 0;
        acc_sq = 0;
        acc_cnt = 0;
        mode_now = MODE_STRAIGHT;
        no_pin.mode = MODE_STRAIGHT;
        no_pin.changed = 1'b0;
        no_pin.variance = '0;

        // Hold reset, then release once
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_threshold(REG_STRAIGHT_ENTER);
        check_threshold(REG_APPROACH_HOLD);

        // Directed frames under reset thresholds of zero
        // single reading at the low end of range: no spread, out of track
        add_step(-13'sd16, 1'b0, 1'b1, 1'b1, MODE_OUT, 1'b1, 32'd0);
        // most negative and most positive patterns
        add_step(-13'sd4096, 1'b0, 1'b0, 1'b0, MODE_STRAIGHT, 1'b0, 32'd0);
        add_step(13'sd4095, 1'b0, 1'b1, 1'b1, MODE_STRAIGHT, 1'b1, 32'd67092481);
        // stuck overrides the choice, variance still reported
        add_step(13'sd5, 1'b0, 1'b0, 1'b0, MODE_STRAIGHT, 1'b0, 32'd0);
        add_step(13'sd7, 1'b1, 1'b1, 1'b1, MODE_STUCK, 1'b1, 32'd4);
        add_step(13'sd3200, 1'b1, 1'b1, 1'b1, MODE_STUCK, 1'b0, 32'd0);
        // too many readings: the twentieth is dropped, the variance saturates
        for (int k = 0; k < SENSORS + 1; k++) begin
            add_step((k % 2 == 0) ? -13'sd4096 : 13'sd4095, 1'b0, k == SENSORS,
                     k == SENSORS, MODE_STRAIGHT, 1'b1, 32'hFFFF_FFFF);
        end
        foreach (script[k]) begin
            feed_reading(script[k].reading, script[k].stuck, script[k].frame_end,
                         script[k].pinned, script[k].verdict);
        end
        i_in_valid <= 1'b0;

        // Random phases, each under its own threshold setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            feed_calm = (p == 3);
            drain_calm = (p == 3);
            case (p)
                0: set_thresholds('1, '1, '1, '1);
                2: set_thresholds('0, '0, '0, '0);
                5: set_thresholds(scaled_random(), scaled_random(), scaled_random(),
                                  scaled_random());
                default: begin
                    se = scaled_random();
                    set_thresholds(se, se >> $urandom_range(0, 2),
                                   se >> $urandom_range(2, 5), se >> $urandom_range(4, 7));
                end
            endcase
            items_fed = 0;
            while (items_fed < PHASE_ITEMS) begin
                feed_random_frame();
            end
            i_in_valid <= 1'b0;
        end
        feed_calm = 0;
        drain_calm = 0;

        // Drain and settle
        for (int w = 0; w < 5000 && pending_verdicts.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            flag_mismatch("frame results never delivered", 0, pending_verdicts.size());
        end
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
